// ----- rtl/core/sha1_hash_engine_unit_assert.svh -----
// Assertion macros for the SHA-1 hash engine.
`ifndef SHA1_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA1_HASH_ENGINE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check an expression at every clock edge outside reset.
`define SHAHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define SHAHE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`else

`define SHAHE_ASSERT(lbl, prop, msg)
`define SHAHE_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

// ----- rtl/core/sha1he_pkg.sv -----
// Types and constants of the SHA-1 hash engine.
`default_nettype none

package sha1he_pkg;

  // Initial chaining value
  localparam logic [31:0] INIT_CV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  // Padding marker byte
  localparam logic [7:0] PAD_MARK = 8'b1000_0000;

  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned LEN_POS    = 56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [2:0]  LAST_INDEX = 3'd4;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_INIT  = 7'b000_0010,
    ST_ROUND = 7'b000_0100,
    ST_ADD   = 7'b000_1000,
    ST_PAD   = 7'b001_0000,
    ST_LEN   = 7'b010_0000,
    ST_OUT   = 7'b100_0000
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha1_hash_engine_unit.sv -----
// SHA-1 hash engine: byte stream in, five digest words out.
//
//  channel  dir  tdata               tuser           tlast
//  s_axis   in   data_byte[7:0]      byte_valid      end_of_message
//  m_axis   out  digest_word[31:0]   word_index[2:0] last_word
//
// The 64th byte of a block starts a compression (load, 80 rounds through the one
// round datapath, add-back). End of message pads one byte a cycle, pausing while
// a full block is compressed, up to the length field, shifts in 8 length bytes,
// runs one or two compressions, then shows five words, one per accepted request.
// Reset is asynchronous; the input is not ready while a block is compressed,
// padded or the digest drains.
`default_nettype none

`include "sha1_hash_engine_unit_assert.svh"

module sha1_hash_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_valid
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last_word
);
  import sha1he_pkg::*;

  state_e       state_q, state_d;
  state_e       ret_q, ret_d;
  logic [5:0]   pos_q, pos_d;
  logic [60:0]  cnt_q, cnt_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic         first_q, first_d;
  logic [31:0]  cv_q [5];
  logic [31:0]  cv_d [5];
  logic [511:0] blk_q, blk_d;
  logic [31:0]  va_q, vb_q, vc_q, vd_q, ve_q;
  logic [31:0]  va_d, vb_d, vc_d, vd_d, ve_d;

  logic         in_acc;
  logic         out_acc;
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic [63:0]  len_bits;
  logic [2:0]   len_sel;
  logic [7:0]   len_byte;
  logic [31:0]  w_cur, w_new;
  logic [31:0]  f_val, k_val, t_val;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Handshake and output drive
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = cv_q[0];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == LAST_INDEX);

  // Length byte for the current position in the last eight bytes
  assign len_bits = {cnt_q, 3'b000};
  assign len_sel  = 3'd7 - pos_q[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  // Round datapath: rolling schedule taps and the round function
  assign w_cur = blk_q[511:480];
  assign w_new = rotl(blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480], 1);

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (vb_q & vc_q) | (~vb_q & vd_q);
      k_val = K_R0;
    end else if (rnd_q < 7'd40) begin
      f_val = vb_q ^ vc_q ^ vd_q;
      k_val = K_R1;
    end else if (rnd_q < 7'd60) begin
      f_val = (vb_q & vc_q) ^ (vb_q & vd_q) ^ (vc_q & vd_q);
      k_val = K_R2;
    end else begin
      f_val = vb_q ^ vc_q ^ vd_q;
      k_val = K_R3;
    end
  end

  assign t_val = rotl(va_q, 5) + f_val + ve_q + k_val + w_cur;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    first_d    = first_q;
    cv_d       = cv_q;
    blk_d      = blk_q;
    va_d       = va_q;
    vb_d       = vb_q;
    vc_d       = vc_q;
    vd_d       = vd_q;
    ve_d       = ve_q;
    shift_en   = 1'b0;
    shift_byte = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          first_d = s_axis_tlast;
          if (s_axis_tuser) begin
            shift_en   = 1'b1;
            shift_byte = s_axis_tdata;
            cnt_d      = cnt_q + 61'd1;
          end
          if (s_axis_tuser && pos_q == LAST_POS) begin
            state_d = ST_INIT;
            ret_d   = s_axis_tlast ? ST_PAD : ST_IDLE;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_INIT: begin
        va_d    = cv_q[0];
        vb_d    = cv_q[1];
        vc_d    = cv_q[2];
        vd_d    = cv_q[3];
        ve_d    = cv_q[4];
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        va_d  = t_val;
        vb_d  = va_q;
        vc_d  = rotl(vb_q, 30);
        vd_d  = vc_q;
        ve_d  = vd_q;
        blk_d = {blk_q[479:0], w_new};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(ROUNDS - 1)) begin
          rnd_d   = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cv_d[0] = cv_q[0] + va_q;
        cv_d[1] = cv_q[1] + vb_q;
        cv_d[2] = cv_q[2] + vc_q;
        cv_d[3] = cv_q[3] + vd_q;
        cv_d[4] = cv_q[4] + ve_q;
        state_d = ret_q;
      end
      ST_PAD: begin
        // Marker first, then zeros up to the length field
        if (first_q) begin
          shift_en   = 1'b1;
          shift_byte = PAD_MARK;
          first_d    = 1'b0;
        end else if (pos_q != 6'(LEN_POS)) begin
          shift_en   = 1'b1;
          shift_byte = '0;
        end else begin
          state_d = ST_LEN;
        end
        if (shift_en && pos_q == LAST_POS) begin
          state_d = ST_INIT;
          ret_d   = ST_PAD;
        end
      end
      ST_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_byte;
        if (pos_q == LAST_POS) begin
          state_d = ST_INIT;
          ret_d   = ST_OUT;
          idx_d   = '0;
        end
      end
      ST_OUT: begin
        // Rotate digest out, refill with the initial value
        if (out_acc) begin
          cv_d[0] = cv_q[1];
          cv_d[1] = cv_q[2];
          cv_d[2] = cv_q[3];
          cv_d[3] = cv_q[4];
          cv_d[4] = INIT_CV[idx_q];
          idx_d   = idx_q + 3'd1;
          if (idx_q == LAST_INDEX) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            pos_d   = '0;
            idx_d   = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte shifter into the block buffer
    if (shift_en) begin
      blk_d = {blk_q[503:0], shift_byte};
      pos_d = pos_q + 6'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
      cv_q    <= INIT_CV;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      cv_q    <= cv_d;
    end
  end

  // Block buffer and working variables
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    va_q  <= va_d;
    vb_q  <= vb_d;
    vc_q  <= vc_d;
    vd_q  <= vd_d;
    ve_q  <= ve_d;
  end

  // Checks
  `SHAHE_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input ready while digest out")
  `SHAHE_ASSERT(a_round_range, rnd_q < 7'(ROUNDS), "round counter out of range")
  `SHAHE_ASSERT_NEXT(a_clear_after_digest, out_acc && m_axis_tlast, s_axis_tready && cnt_q == '0 && pos_q == '0, "count not cleared after digest")

endmodule

`default_nettype wire

// ----- tb/sv/sha1_digest_checker.sv -----
// Checker for the SHA-1 hash engine: predicts digests from byte requests and checks the output.
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,    // [7:0] data_byte
  input  wire logic        s_tuser_i,    // [0] byte_valid
  input  wire logic        s_tlast_i,    // end_of_message
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [31:0] m_tdata_i,    // [31:0] digest_word
  input  wire logic [2:0]  m_tuser_i,    // [2:0] word_index
  input  wire logic        m_tlast_i,    // last_word
  output int               fail_count_o,
  output int               pending_o,
  output int               words_checked_o
);
  import sha1he_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Shadow state of the hash engine
  logic [31:0]  chain_h [5];
  logic [7:0]   blk_b [64];
  logic [60:0]  byte_cnt;
  logic [5:0]   blk_pos;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Start a new message: initial chaining value, count cleared
  function automatic void restart_message();
    for (int i = 0; i < 5; i++) chain_h[i] = INIT_CV[i];
    byte_cnt = '0;
    blk_pos  = '0;
  endfunction

  // Run 80 rounds over the current 64-byte block and add into the chaining value
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wr;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_b[4*i], blk_b[4*i+1], blk_b[4*i+2], blk_b[4*i+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rol32(w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[r%16], 1);
        w[r%16] = wr;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) ^ (b & d) ^ (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rol32(a, 5) + f + e + k + wr;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Take one accepted request; on end of message pad and queue the five digest words
  function automatic void absorb_request(input logic [7:0] d, input logic u, input logic l);
    logic [63:0] bit_len;
    int p;
    if (u) begin
      blk_b[blk_pos] = d;
      byte_cnt = byte_cnt + 61'd1;
      blk_pos  = blk_pos + 6'd1;
      if (blk_pos == 6'd0) compress_block();
    end
    if (l) begin
      p = int'(blk_pos);
      blk_b[p] = PAD_MARK;
      for (int i = p + 1; i < 64; i++) blk_b[i] = 8'h00;
      // no room for the length: flush this block, length goes in a fresh one
      if (p >= LEN_POS) begin
        compress_block();
        for (int i = 0; i < 64; i++) blk_b[i] = 8'h00;
      end
      bit_len = {byte_cnt, 3'b000};
      for (int i = 0; i < 8; i++) blk_b[LEN_POS+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 5; i++)
        digest_q.push_back('{chain_h[i], 3'(i), (3'(i) == LAST_INDEX)});
      restart_message();
    end
  endfunction

  // Predict on input requests, compare on output requests
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      words_checked_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %b", $time,
                   m_tdata_i, m_tuser_i, m_tlast_i);
          fail_count_o++;
        end else begin
          exp_w = digest_q.pop_front();
          words_checked_o++;
          if (m_tdata_i !== exp_w.word || m_tuser_i !== exp_w.index ||
              m_tlast_i !== exp_w.last) begin
            if (m_tdata_i !== exp_w.word)
              $display("%0t: digest_word expected %h actual %h", $time, exp_w.word, m_tdata_i);
            if (m_tuser_i !== exp_w.index)
              $display("%0t: word_index expected %0d actual %0d", $time, exp_w.index,
                       m_tuser_i);
            if (m_tlast_i !== exp_w.last)
              $display("%0t: last_word expected %b actual %b", $time, exp_w.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) absorb_request(s_tdata_i, s_tuser_i, s_tlast_i);
      pending_o = digest_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_sha1_hash_engine_unit.sv -----
// Testbench top for the SHA-1 hash engine: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_sha1_hash_engine_unit;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] byte_valid
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser;   // [2:0] word_index
  logic        m_axis_tlast;   // last_word

  int fail_count;
  int pending_words;
  int words_checked;
  int item_cnt;
  int msg_cnt;
  int byte_total;
  bit calm;

  sha1_hash_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha1_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .words_checked_o (words_checked)
  );

  // Free-running clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the digest output at random, except during the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // Hard stop in case the engine hangs
  initial begin
    #5_000_000;
    $display("** sha1_hash_engine_unit: FAILED **");
    $finish;
  end

  // Offer one request, with random gaps before it; return at the falling edge after acceptance
  task automatic send_request(input logic [7:0] d, input logic u, input logic l);
    while (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= u;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // Send a message of random bytes, ending on the last byte or with an empty end request
  task automatic send_message(input int len, input bit end_on_byte);
    logic last_flag;
    for (int i = 0; i < len; i++) begin
      // sprinkle idle requests that the engine must ignore
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      last_flag = end_on_byte && (i == len - 1);
      send_request(8'($urandom), 1'b1, last_flag);
      item_cnt++;
      byte_total++;
    end
    if (!end_on_byte || len == 0) begin
      send_request(8'($urandom), 1'b0, 1'b1);
      item_cnt++;
    end
    msg_cnt++;
  endtask

  initial begin
    int len;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    item_cnt      = 0;
    msg_cnt       = 0;
    byte_total    = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty message as a lone end request
    send_request(8'h5a, 1'b0, 1'b1);
    // idle request, then a single 0xff byte that carries the end
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    // single 0x00 byte closed by an empty end request
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    // "abc", end on the last byte
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    item_cnt   += 7;
    byte_total += 5;
    msg_cnt    += 4;

    // Random messages; a few land on the padding boundaries and the full-block case
    while (item_cnt < 270) begin
      calm = (msg_cnt >= 9 && msg_cnt <= 12);
      case (msg_cnt)
        7:       len = 55;
        10:      len = 56;
        14:      len = 64;
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len, $urandom_range(0, 1));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain the remaining digest words, then let the engine settle
    while (pending_words != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d messages, %0d bytes, %0d counted requests.", msg_cnt, byte_total,
             item_cnt);
    $display("Checked %0d digest words under random input gaps and output stalls.",
             words_checked);
    if (fail_count == 0) begin
      $display("** sha1_hash_engine_unit: PASSED **");
    end else begin
      $display("** sha1_hash_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
